FILE: design/ptd_pkg.sv
package ptd_pkg;

  // Sizing of the queue and slot store.
  localparam int NUM_QUEUES      = 4;
  localparam int TASKS_PER_QUEUE = 8;
  localparam int TASK_ID_BITS    = 8;
  localparam int Q_BITS          = 2;
  localparam int S_BITS          = 3;
  localparam int ADDR_BITS       = Q_BITS + S_BITS;
  localparam int TOTAL_SLOTS     = NUM_QUEUES * TASKS_PER_QUEUE;
  localparam int NUM_PERIOD_REGS = 4;

  // Configuration port widths and field widths.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int QC_BITS       = 3;
  localparam int PERIOD_BITS   = 16;
  localparam int TICK_BITS     = 32;
  localparam int TICK_CNT_BITS = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_Q0   = 3'd1;

  // Input actions.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_REMOVE   = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  queue_sel;
    logic [2:0]  slot_sel;
    logic [7:0]  task_id;
    logic [31:0] tick_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic [1:0] queue_out;
    logic [2:0] slot_out;
    logic [7:0] task_out;
    logic       last;
  } out_item_t;

  // Control of the remainder units, shared by all of them.
  typedef struct packed {
    logic load;
    logic step;
    logic dbit;
  } rem_ctl_t;

  // Index of the lowest set bit of a slot bitmap; zero when none is set.
  function automatic logic [S_BITS-1:0] lowest_set(input logic [TASKS_PER_QUEUE-1:0] bits);
    logic [S_BITS-1:0] idx;
    idx = '0;
    for (int i = TASKS_PER_QUEUE - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = S_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: design/ptd_task_ram.sv
module ptd_task_ram import ptd_pkg::*; (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_BITS-1:0]    waddr,
  input  logic [TASK_ID_BITS-1:0] wdata,
  input  logic                    re,
  input  logic [ADDR_BITS-1:0]    raddr,
  output logic [TASK_ID_BITS-1:0] rdata
);

  logic [TASK_ID_BITS-1:0] mem [TOTAL_SLOTS];
  logic [TASK_ID_BITS-1:0] rdata_r;

  // One write port, one read port with registered data held between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ptd_rem_unit.sv
module ptd_rem_unit import ptd_pkg::*; (
  input  logic                   clk,
  input  rem_ctl_t               ctl,
  input  logic [PERIOD_BITS-1:0] period,
  output logic                   rem_zero
);

  logic [PERIOD_BITS-1:0] div_r, div_nxt;
  logic [PERIOD_BITS-1:0] rem_r, rem_nxt;
  logic [PERIOD_BITS:0]   trial;

  // Restoring remainder, one dividend bit per step, most significant first.
  always_comb begin
    div_nxt = div_r;
    rem_nxt = rem_r;
    trial   = {rem_r, ctl.dbit};
    if (ctl.load) begin
      // A period of zero behaves as a period of one.
      div_nxt = (period == '0) ? PERIOD_BITS'(1) : period;
      rem_nxt = '0;
    end else if (ctl.step) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = PERIOD_BITS'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[PERIOD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rem_zero = (rem_r == '0);

endmodule

FILE: design/periodic_task_dispatcher.sv
// Add and remove items: the reply is registered in the cycle after the item is taken.
// Tick items: bit-serial period checks over the 32 tick bits (all queues in parallel),
// then a walk that reads each dispatched task (S_SCAN, S_READ), steps through the queues
// in use and ends with the end item; the walk waits while results are stalled.
// One item is worked on at a time. Reset (synchronous, rst_n low) clears the
// presence bitmaps, sets the queue count to 0 and every period to 1.
module periodic_task_dispatcher import ptd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [QC_BITS-1:0]         queue_count_r, queue_count_nxt;
  logic [PERIOD_BITS-1:0]     period_r [NUM_QUEUES];
  logic [PERIOD_BITS-1:0]     period_nxt [NUM_QUEUES];
  logic [TASKS_PER_QUEUE-1:0] present_r [NUM_QUEUES];
  logic [TASKS_PER_QUEUE-1:0] present_nxt [NUM_QUEUES];
  logic [TICK_BITS-1:0]       tick_r, tick_nxt;
  logic [TICK_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [Q_BITS-1:0]          q_r, q_nxt;
  logic [S_BITS-1:0]          slot_r, slot_nxt;
  logic [TASKS_PER_QUEUE-1:0] taken_r, taken_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  logic [QC_BITS-1:0]         nq;
  logic                       out_free;
  logic                       accept;
  logic                       qsel_ok;
  logic [TASKS_PER_QUEUE-1:0] sel_bits;
  logic [TASKS_PER_QUEUE-1:0] pending;
  logic [S_BITS-1:0]          pick;
  logic [NUM_QUEUES-1:0]      due;
  rem_ctl_t                   rem_ctl;
  logic                       ram_we;
  logic [ADDR_BITS-1:0]       ram_waddr;
  logic                       ram_re;
  logic [ADDR_BITS-1:0]       ram_raddr;
  logic [TASK_ID_BITS-1:0]    ram_rdata;

  // Task identifier store.
  ptd_task_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.task_id),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One remainder unit per queue decides whether its period divides the tick.
  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_rem
    ptd_rem_unit u_rem (
      .clk      (clk),
      .ctl      (rem_ctl),
      .period   (period_r[g]),
      .rem_zero (due[g])
    );
  end

  // Handshake and shared decode.
  assign nq        = (queue_count_r > QC_BITS'(NUM_QUEUES)) ? QC_BITS'(NUM_QUEUES)
                                                            : queue_count_r;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign qsel_ok   = (QC_BITS'(in_item.queue_sel) < nq);
  assign sel_bits  = present_r[in_item.queue_sel];
  assign pending   = due[q_r] ? (present_r[q_r] & ~taken_r) : '0;
  assign pick      = lowest_set(pending);
  assign ram_raddr = {q_r, pick};

  // Configuration writes.
  always_comb begin
    queue_count_nxt = queue_count_r;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      period_nxt[q] = period_r[q];
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_QUEUE_COUNT) begin
        queue_count_nxt = cfg_data[QC_BITS-1:0];
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (q < NUM_PERIOD_REGS && cfg_index == CFG_IDX_BITS'(CFG_PERIOD_Q0 + q)) begin
          period_nxt[q] = cfg_data[PERIOD_BITS-1:0];
        end
      end
    end
  end

  // Main sequencer: item acceptance, tick division, and the dispatch walk.
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    slot_nxt      = slot_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      present_nxt[q] = present_r[q];
    end
    rem_ctl       = '0;
    ram_we        = 1'b0;
    ram_waddr     = {in_item.queue_sel, lowest_set(~sel_bits)};
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt           = '0;
          out_item_nxt.queue_out = in_item.queue_sel;
          out_item_nxt.last      = 1'b1;
          case (in_item.action)
            ACT_ADD: begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.kind = KIND_ADD;
              if (qsel_ok && !(&sel_bits)) begin
                ram_we                 = 1'b1;
                out_item_nxt.ok        = 1'b1;
                out_item_nxt.slot_out  = lowest_set(~sel_bits);
                present_nxt[in_item.queue_sel] =
                  sel_bits | (TASKS_PER_QUEUE'(1) << lowest_set(~sel_bits));
              end
            end
            ACT_REMOVE: begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.kind     = KIND_REMOVE;
              out_item_nxt.slot_out = in_item.slot_sel;
              if (qsel_ok && sel_bits[in_item.slot_sel]) begin
                out_item_nxt.ok = 1'b1;
                present_nxt[in_item.queue_sel] =
                  sel_bits & ~(TASKS_PER_QUEUE'(1) << in_item.slot_sel);
              end
            end
            ACT_TICK: begin
              if (nq == '0) begin
                // No queues in use: a lone failing end item.
                out_valid_nxt          = 1'b1;
                out_item_nxt.kind      = KIND_END;
                out_item_nxt.queue_out = '0;
              end else begin
                rem_ctl.load = 1'b1;
                tick_nxt     = in_item.tick_value;
                cnt_nxt      = '0;
                state_nxt    = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        rem_ctl.step = 1'b1;
        rem_ctl.dbit = tick_r[TICK_BITS-1];
        tick_nxt     = {tick_r[TICK_BITS-2:0], 1'b0};
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == TICK_CNT_BITS'(TICK_BITS - 1)) begin
          q_nxt     = '0;
          taken_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pending != '0) begin
          ram_re    = 1'b1;
          slot_nxt  = pick;
          state_nxt = S_READ;
        end else if (QC_BITS'(q_r) + 1'b1 < nq) begin
          q_nxt     = q_r + 1'b1;
          taken_nxt = '0;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = '0;
          out_item_nxt.kind = KIND_END;
          out_item_nxt.ok   = 1'b1;
          out_item_nxt.last = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_READ: begin
        // Read data stays in the memory's output register until taken here.
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.kind      = KIND_DISPATCH;
          out_item_nxt.ok        = 1'b1;
          out_item_nxt.queue_out = q_r;
          out_item_nxt.slot_out  = slot_r;
          out_item_nxt.task_out  = ram_rdata;
          out_item_nxt.last      = 1'b0;
          taken_nxt              = taken_r | (TASKS_PER_QUEUE'(1) << slot_r);
          state_nxt              = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      queue_count_r <= '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        period_r[q]  <= PERIOD_BITS'(1);
        present_r[q] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      queue_count_r <= queue_count_nxt;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        period_r[q]  <= period_nxt[q];
        present_r[q] <= present_nxt[q];
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    tick_r     <= tick_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    slot_r     <= slot_nxt;
    taken_r    <= taken_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: tb/sv/tb_periodic_task_dispatcher.sv
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher;
  import ptd_pkg::*;

  // Action code that the block must ignore, and a register index with no register behind it.
  localparam logic [1:0]              ACT_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int                      SETTLE_CYCLES  = 150;
  localparam int                      ITEMS_PER_RUN  = 60;

  // Shadow of the queues, slots and periods, plus the results still owed by the block.
  class dispatch_shadow;
    logic [QC_BITS-1:0]         queue_count;
    logic [PERIOD_BITS-1:0]     period [NUM_PERIOD_REGS];
    logic [TASKS_PER_QUEUE-1:0] present [NUM_QUEUES];
    logic [TASK_ID_BITS-1:0]    task_ids [TOTAL_SLOTS];
    out_item_t                  owed [$];
    int                         errors;

    function new();
      queue_count = '0;
      errors = 0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        period[q] = PERIOD_BITS'(1);
        present[q] = '0;
      end
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        task_ids[i] = '0;
      end
    endfunction

    // A count above the number of queues behaves as all queues.
    function int active_queues();
      return (queue_count > NUM_QUEUES) ? NUM_QUEUES : int'(queue_count);
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == CFG_QUEUE_COUNT) begin
        queue_count = data[QC_BITS-1:0];
      end else if (idx >= CFG_PERIOD_Q0 &&
                   int'(idx) < int'(CFG_PERIOD_Q0) + NUM_PERIOD_REGS) begin
        period[idx - CFG_PERIOD_Q0] = data[PERIOD_BITS-1:0];
      end
    endfunction

    function void owe(logic [1:0] kind, logic ok, int q, int s, logic [7:0] tid, logic last);
      out_item_t r;
      r.kind      = kind;
      r.ok        = ok;
      r.queue_out = q[Q_BITS-1:0];
      r.slot_out  = s[S_BITS-1:0];
      r.task_out  = tid;
      r.last      = last;
      owed.push_back(r);
    endfunction

    // Update the shadow for an accepted item and record the results it causes.
    function void apply_item(in_item_t it);
      int nq;
      int q;
      int free_slot;
      logic [31:0] per;
      nq = active_queues();
      q = int'(it.queue_sel);
      case (it.action)
        ACT_ADD: begin
          free_slot = -1;
          if (q < nq) begin
            for (int s = TASKS_PER_QUEUE - 1; s >= 0; s--) begin
              if (!present[q][s]) free_slot = s;
            end
          end
          if (free_slot < 0) begin
            owe(KIND_ADD, 1'b0, q, 0, '0, 1'b1);
          end else begin
            present[q][free_slot] = 1'b1;
            task_ids[q * TASKS_PER_QUEUE + free_slot] = it.task_id;
            owe(KIND_ADD, 1'b1, q, free_slot, '0, 1'b1);
          end
        end
        ACT_REMOVE: begin
          if (q < nq && present[q][it.slot_sel]) begin
            present[q][it.slot_sel] = 1'b0;
            owe(KIND_REMOVE, 1'b1, q, int'(it.slot_sel), '0, 1'b1);
          end else begin
            owe(KIND_REMOVE, 1'b0, q, int'(it.slot_sel), '0, 1'b1);
          end
        end
        ACT_TICK: begin
          if (nq == 0) begin
            owe(KIND_END, 1'b0, 0, 0, '0, 1'b1);
          end else begin
            for (int qq = 0; qq < nq; qq++) begin
              // A zero period behaves as one, so the queue is due every tick.
              per = (period[qq] == 0) ? 32'd1 : {16'd0, period[qq]};
              if (it.tick_value % per == 0) begin
                for (int s = 0; s < TASKS_PER_QUEUE; s++) begin
                  if (present[qq][s]) begin
                    owe(KIND_DISPATCH, 1'b1, qq, s, task_ids[qq * TASKS_PER_QUEUE + s], 1'b0);
                  end
                end
              end
            end
            owe(KIND_END, 1'b1, 0, 0, '0, 1'b1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare a result item from the block with the oldest owed result.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("result item with none outstanding: %h", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("ok", 32'(want.ok), 32'(got.ok));
      compare_field("queue_out", 32'(want.queue_out), 32'(got.queue_out));
      compare_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
      compare_field("task_out", 32'(want.task_out), 32'(got.task_out));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  bit             tx_idle = 1'b0;
  bit             rx_idle = 1'b0;
  dispatch_shadow shadow;

  periodic_task_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t mk(logic [1:0] act, int q, int s, logic [7:0] tid,
                                  logic [31:0] tick);
    in_item_t it;
    it.action     = act;
    it.queue_sel  = q[Q_BITS-1:0];
    it.slot_sel   = s[S_BITS-1:0];
    it.task_id    = tid;
    it.tick_value = tick;
    return it;
  endfunction

  function automatic logic [PERIOD_BITS-1:0] random_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(1, 6));
      default: return 16'($urandom);
    endcase
  endfunction

  // Tick counts lean towards multiples of a configured period so that queues fall due.
  function automatic logic [31:0] random_tick();
    int q;
    logic [31:0] per;
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return 32'($urandom_range(0, 16));
      default: begin
        q = $urandom_range(0, NUM_QUEUES - 1);
        per = (shadow.period[q] == 0) ? 32'd1 : {16'd0, shadow.period[q]};
        return per * 32'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // Random item: mostly aimed at configured queues and present slots, with some noise.
  function automatic in_item_t random_item(int add_w, int rem_w);
    in_item_t    it;
    logic [63:0] raw;
    int          nq;
    int          pick;
    int          q;
    int          cand [$];
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    nq = shadow.active_queues();
    if (nq > 0 && $urandom_range(0, 99) < 85) it.queue_sel = Q_BITS'($urandom_range(0, nq - 1));
    pick = $urandom_range(0, 99);
    if (pick < add_w) begin
      it.action = ACT_ADD;
    end else if (pick < add_w + rem_w) begin
      it.action = ACT_REMOVE;
      q = int'(it.queue_sel);
      if (shadow.present[q] != 0 && $urandom_range(0, 3) != 0) begin
        for (int s = 0; s < TASKS_PER_QUEUE; s++) begin
          if (shadow.present[q][s]) cand.push_back(s);
        end
        it.slot_sel = S_BITS'(cand[$urandom_range(0, cand.size() - 1)]);
      end
    end else if (pick < 97) begin
      it.action = ACT_TICK;
      it.tick_value = random_tick();
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  // Offer one item, after a random gap when tx_idle is set, and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    shadow.apply_item(it);
  endtask

  // The caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    shadow.write_reg(idx, data);
  endtask

  // Stop sending, let every owed result arrive, then allow for work on ignored items.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config(bit all_queues);
    logic [CFG_DATA_BITS-1:0] data;
    data = 16'($urandom);
    if (all_queues) data[QC_BITS-1:0] = QC_BITS'(NUM_QUEUES);
    write_reg(CFG_QUEUE_COUNT, data);
    for (int q = 0; q < NUM_PERIOD_REGS; q++) begin
      write_reg(CFG_IDX_BITS'(CFG_PERIOD_Q0 + q), all_queues ? 16'd1 : random_period());
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: when rx_idle is set, stall for a random number of cycles before taking each item.
  initial begin
    int w;
    wait (rst_n === 1'b1);
    forever begin
      w = rx_idle ? $urandom_range(0, 13) : 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      shadow.check_reply(out_item);
    end
  end

  initial begin
    int add_w;
    int rem_w;
    shadow = new();
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // With no queues configured every item fails, and the unused action is ignored.
    send_item(mk(ACT_TICK, 0, 0, 8'h00, 32'd0));
    send_item(mk(ACT_ADD, 0, 0, 8'hFF, 32'd0));
    send_item(mk(ACT_REMOVE, 0, 0, 8'h00, 32'd0));
    send_item(mk(ACT_UNUSED, 3, 7, 8'hFF, 32'hFFFF_FFFF));
    settle();

    // Count above the number of queues, zero and largest periods, a write to no register.
    write_reg(CFG_QUEUE_COUNT, 16'hFFFF);
    write_reg(CFG_PERIOD_Q0, 16'd1);
    write_reg(CFG_IDX_BITS'(CFG_PERIOD_Q0 + 1), 16'd0);
    write_reg(CFG_IDX_BITS'(CFG_PERIOD_Q0 + 2), 16'd2);
    write_reg(CFG_IDX_BITS'(CFG_PERIOD_Q0 + 3), 16'hFFFF);
    write_reg(CFG_UNUSED_IDX, 16'h5A5A);
    cfg_valid <= 1'b0;

    // Fill queue 0, then one add more than it holds.
    send_item(mk(ACT_ADD, 0, 0, 8'h00, 32'd0));
    send_item(mk(ACT_ADD, 0, 0, 8'hFF, 32'd0));
    send_item(mk(ACT_ADD, 0, 0, 8'h55, 32'd0));
    send_item(mk(ACT_ADD, 0, 0, 8'hAA, 32'd0));
    for (int i = 4; i < TASKS_PER_QUEUE + 1; i++) begin
      send_item(mk(ACT_ADD, 0, 7, 8'(8'h10 + i), 32'hFFFF_FFFF));
    end
    send_item(mk(ACT_ADD, 3, 0, 8'hFF, 32'd0));
    send_item(mk(ACT_ADD, 1, 0, 8'h3C, 32'd0));
    send_item(mk(ACT_TICK, 3, 7, 8'hFF, 32'd0));
    send_item(mk(ACT_TICK, 0, 0, 8'h00, 32'hFFFF_FFFF));
    // Remove present and absent slots, then reuse the freed slot.
    send_item(mk(ACT_REMOVE, 0, 7, 8'h00, 32'd0));
    send_item(mk(ACT_REMOVE, 0, 7, 8'h00, 32'd0));
    send_item(mk(ACT_REMOVE, 3, 0, 8'hFF, 32'd0));
    send_item(mk(ACT_ADD, 0, 0, 8'h81, 32'd0));
    send_item(mk(ACT_TICK, 0, 0, 8'h00, 32'd196605));
    settle();

    // Only queue 0 configured: the other queues refuse adds and removes.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(CFG_QUEUE_COUNT, 16'd1);
    cfg_valid <= 1'b0;
    send_item(mk(ACT_ADD, 2, 0, 8'h42, 32'd0));
    send_item(mk(ACT_REMOVE, 1, 0, 8'h00, 32'd0));
    send_item(mk(ACT_TICK, 0, 0, 8'h00, 32'd2));

    // Random runs, each with new settings and one of three mixes of adds and removes.
    for (int run = 0; run < 6; run++) begin
      settle();
      random_config(run == 1);
      tx_idle = (run != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (run != 0) && ($urandom_range(0, 3) != 0);
      case (run % 3)
        0:       begin add_w = 35; rem_w = 30; end
        1:       begin add_w = 70; rem_w = 5;  end
        default: begin add_w = 20; rem_w = 45; end
      endcase
      for (int i = 0; i < ITEMS_PER_RUN; i++) begin
        // Once, hold the sender back until the block has caught up.
        if (run == 2 && i == ITEMS_PER_RUN / 2) settle();
        send_item(random_item(add_w, rem_w));
      end
    end

    settle();
    if (shadow.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a block that stops responding.
  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
design/ptd_pkg.sv
design/ptd_task_ram.sv
design/ptd_rem_unit.sv
design/periodic_task_dispatcher.sv
tb/sv/tb_periodic_task_dispatcher.sv
